// ===== rtl/fenwick_count_greater_defines.svh =====
// ----------------------------------------------------------------------------
// Fenwick count-greater assertion macros
// Shared concurrent assertion helpers for the rank counter RTL.
// ----------------------------------------------------------------------------
`ifndef FENWICK_COUNT_GREATER_DEFINES_SVH
`define FENWICK_COUNT_GREATER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define FCG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcg: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcg: next-cycle property failed");

`else

`define FCG_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define FCG_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/fcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater package
// Field widths, operation codes and control types shared by the design.
// ----------------------------------------------------------------------------
package fcg_pkg;

    // Fixed field widths of the ports.
    localparam int FUNC_W = 1;
    localparam int RANK_W = 11;
    localparam int CFG_W  = 11;
    localparam int OUT_W  = 16;

    // Reset value of the highest rank in use.
    localparam logic [CFG_W-1:0] USED_SIZE_RESET = 11'd1024;

    // Operation codes of a request.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 1'b1;

    // Tree walker states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } walk_state_t;

    // Control from the top level to the walker.
    typedef struct packed {
        logic go;
        logic is_query;
        logic done_ack;
    } walk_ctl_t;

    // Status from the walker to the top level.
    typedef struct packed {
        logic ready;
        logic done;
    } walk_sts_t;

endpackage

// ===== rtl/fcg_item_if.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater request channel
// Valid/ready channel carrying one insert or query request.
// ----------------------------------------------------------------------------
interface fcg_item_if;
    import fcg_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output func, output rank, input ready);
    modport sink   (input valid, input func, input rank, output ready);
endinterface

// ===== rtl/fcg_result_if.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface fcg_result_if;
    import fcg_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] greater_count;
    logic             rejected;

    modport source (output valid, output greater_count, output rejected, input ready);
    modport sink   (input valid, input greater_count, input rejected, output ready);
endinterface

// ===== rtl/fcg_ram.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fcg_walk.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater tree walker
// Clears the node RAM after reset, then walks the tree one node per cycle:
// upward with a read-modify-write for an insert, downward with a running
// sum for a query. Reads and write-backs overlap in a two-stage pipeline.
// ----------------------------------------------------------------------------
`include "fenwick_count_greater_defines.svh"

module fcg_walk #(
    parameter int MAX_RANKS  = 1024,
    parameter int COUNT_BITS = 16,
    localparam int ADDR_W    = $clog2(MAX_RANKS),
    localparam int POS_W     = (ADDR_W + 2 > fcg_pkg::RANK_W + 1) ? ADDR_W + 2
                                                                  : fcg_pkg::RANK_W + 1,
    localparam int SUM_W     = COUNT_BITS + $clog2(ADDR_W + 2)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fcg_pkg::walk_ctl_t  ctl,
    input  logic [POS_W-1:0]    start_pos,
    input  logic [POS_W-1:0]    lim,
    output fcg_pkg::walk_sts_t  sts,
    output logic [SUM_W-1:0]    sum
);
    import fcg_pkg::*;

    walk_state_t state_reg, state_next;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      low_bit;
    logic [POS_W-1:0]      pos_m1;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                  query_reg, query_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  in_range;
    logic                  clr_last;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;

    // Node storage, one entry per rank, entry address is rank minus one.
    fcg_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_RANKS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Lowest set bit of the current node and the range check of the walk.
    assign low_bit  = pos_reg & (~pos_reg + POS_W'(1));
    assign pos_m1   = pos_reg - POS_W'(1);
    assign in_range = (pos_reg != '0) && (pos_reg <= lim);
    assign clr_last = (clr_addr_reg == ADDR_W'(MAX_RANKS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (ctl.go)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!in_range)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctl.done_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath and RAM port control per state.
    always_comb
    begin
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        clr_addr_next  = clr_addr_reg;
        query_next     = query_reg;
        sum_next       = sum_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mem_rdata + COUNT_BITS'(1);
        mem_re         = 1'b0;
        mem_raddr      = pos_m1[ADDR_W-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                pend_next = 1'b0;
                if (ctl.go)
                begin
                    pos_next   = start_pos;
                    query_next = ctl.is_query;
                    sum_next   = '0;
                end
            end
            ST_WALK:
            begin
                // Issue the read of this node, finish the node read last cycle.
                mem_re         = in_range;
                pend_next      = in_range;
                pend_addr_next = pos_m1[ADDR_W-1:0];
                if (pend_reg)
                begin
                    if (query_reg)
                    begin
                        sum_next = sum_reg + SUM_W'(mem_rdata);
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
                if (query_reg)
                begin
                    pos_next = pos_reg - low_bit;
                end
                else
                begin
                    pos_next = pos_reg + low_bit;
                end
            end
            ST_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pend_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        pend_addr_reg <= pend_addr_next;
        query_reg     <= query_next;
        sum_reg       <= sum_next;
    end

    assign sts.ready = (state_reg == ST_IDLE);
    assign sts.done  = (state_reg == ST_DONE);
    assign sum       = sum_reg;

    // A write-back never targets the node being read in the same cycle.
    `FCG_ASSERT_IMP(a_no_rw_collide, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)
    // The pipeline is drained whenever a result is offered.
    `FCG_ASSERT_IMP(a_done_drained, clk, rst_n, state_reg == ST_DONE, !pend_reg)
    // A new request never starts with a node still in flight.
    `FCG_ASSERT_IMP(a_idle_drained, clk, rst_n, sts.ready, !pend_reg && !mem_we)

endmodule

// ===== rtl/fenwick_count_greater.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater
// Binary indexed tree of rank occurrence counts. An insert adds one at a
// rank; a query returns how many inserted ranks are strictly greater.
//
//   Channel  Dir  Handshake        Payload
//   item     in   valid/ready      func, rank
//   result   out  valid/ready      greater_count, rejected
//   cfg      in   cfg_we (no wait) cfg_wdata = used_size
//
// A request is accepted only while the walker is idle; the walk visits k tree
// nodes, at most log2(MAX_RANKS)+1, which for 1024 ranks is 11 nodes. The
// walk is bound by the single read port of the node RAM.
// After reset the node RAM is cleared one entry at a time over all MAX_RANKS
// entries; no request is taken meanwhile, configuration writes are.
// The result sits in an output register, so a stalled result does not hold
// up acceptance of the next request; only its completion waits.
// ----------------------------------------------------------------------------
`include "fenwick_count_greater_defines.svh"

module fenwick_count_greater #(
    parameter int MAX_RANKS  = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [fcg_pkg::CFG_W-1:0]  cfg_wdata,
    fcg_item_if.sink                   item,
    fcg_result_if.source               result
);
    import fcg_pkg::*;

    localparam int ADDR_W = $clog2(MAX_RANKS);
    localparam int POS_W  = (ADDR_W + 2 > RANK_W + 1) ? ADDR_W + 2 : RANK_W + 1;
    localparam int SUM_W  = COUNT_BITS + $clog2(ADDR_W + 2);
    localparam int RES_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    localparam logic [POS_W-1:0]      MAX_POS   = POS_W'(MAX_RANKS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    walk_ctl_t             ctl;
    walk_sts_t             sts;
    logic [SUM_W-1:0]      sum;
    logic [POS_W-1:0]      start_pos;
    logic [POS_W-1:0]      lim;
    logic [POS_W-1:0]      size_w;
    logic [POS_W-1:0]      rank_w;

    logic [CFG_W-1:0]      used_size_reg, used_size_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  query_reg, query_next;
    logic                  rej_reg, rej_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      greater_count_reg, greater_count_next;
    logic                  rejected_reg, rejected_next;

    logic                  accept;
    logic                  is_ins;
    logic                  is_qry;
    logic                  full;
    logic                  ins_ok;
    logic [RES_W-1:0]      tot_ext;
    logic [RES_W-1:0]      sum_ext;
    logic [RES_W-1:0]      diff;

    fcg_walk #(
        .MAX_RANKS  (MAX_RANKS),
        .COUNT_BITS (COUNT_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .start_pos (start_pos),
        .lim       (lim),
        .sts       (sts),
        .sum       (sum)
    );

    // Effective rank limit: used_size clamped to 1..MAX_RANKS.
    assign size_w = POS_W'(used_size_reg);
    assign lim    = (size_w == '0) ? POS_W'(1) : ((size_w > MAX_POS) ? MAX_POS : size_w);

    // Request decode.
    assign accept     = item.valid && item.ready;
    assign item.ready = sts.ready;
    assign rank_w     = POS_W'(item.rank);
    assign is_ins     = (item.func == FUNC_INSERT);
    assign is_qry     = (item.func == FUNC_QUERY);
    assign full       = (total_reg == COUNT_MAX);
    assign ins_ok     = !full && (rank_w != '0) && (rank_w <= lim);

    // Starting node: the clamped rank for a query, none for a dropped insert.
    always_comb
    begin
        if (is_qry)
        begin
            start_pos = (rank_w > lim) ? lim : rank_w;
        end
        else if (ins_ok)
        begin
            start_pos = rank_w;
        end
        else
        begin
            start_pos = '0;
        end
    end

    assign ctl.go       = accept;
    assign ctl.is_query = is_qry;
    assign ctl.done_ack = sts.done && (!out_valid_reg || result.ready);

    // Configuration, running total and per-request flags.
    assign used_size_next = cfg_we ? cfg_wdata : used_size_reg;
    assign total_next     = (accept && is_ins && ins_ok) ? total_reg + COUNT_BITS'(1)
                                                         : total_reg;
    assign query_next     = accept ? is_qry : query_reg;
    assign rej_next       = accept ? (is_ins && full) : rej_reg;

    // Count above the rank, saturated at zero.
    assign tot_ext = RES_W'(total_reg);
    assign sum_ext = RES_W'(sum);
    assign diff    = (sum_ext > tot_ext) ? '0 : tot_ext - sum_ext;

    // Output register.
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        greater_count_next = greater_count_reg;
        rejected_next      = rejected_reg;
        if (ctl.done_ack)
        begin
            out_valid_next     = 1'b1;
            greater_count_next = query_reg ? diff[OUT_W-1:0] : '0;
            rejected_next      = rej_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_size_reg <= USED_SIZE_RESET;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_size_reg <= used_size_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        query_reg         <= query_next;
        rej_reg           <= rej_next;
        greater_count_reg <= greater_count_next;
        rejected_reg      <= rejected_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.greater_count = greater_count_reg;
    assign result.rejected      = rejected_reg;

    // An accepted request occupies the walker on the next cycle.
    `FCG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, !item.ready)
    // A refused insert leaves the running total untouched.
    `FCG_ASSERT_NXT(a_full_keeps_total, clk, rst_n, accept && is_ins && full, total_reg == COUNT_MAX)
    // A refused insert reports a zero count.
    `FCG_ASSERT_IMP(a_rej_zero_count, clk, rst_n, result.valid && result.rejected, result.greater_count == '0)

endmodule

// ===== tb/fcg_answer_checker.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater answer checker
// Watches the request, result and register ports of the rank counter. It
// keeps its own copy of the tree nodes, the inserted total and the rank
// limit, predicts the answer to every accepted request, and compares each
// accepted result, field by field, with the oldest predicted answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcg_answer_checker #(
    parameter int MAX_RANKS  = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [fcg_pkg::CFG_W-1:0] cfg_wdata,
    fcg_item_if                       req,
    fcg_result_if                     res,
    output int                        n_pending,
    output int                        n_errors
);
    import fcg_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic [OUT_W-1:0] greater_count;
        logic             rejected;
    } answer_t;

    // Mirror of the block state.
    logic [COUNT_BITS-1:0] node_count [1:MAX_RANKS];
    logic [COUNT_BITS-1:0] inserted_total;
    logic [CFG_W-1:0]      used_size;

    answer_t pending_answers [$];

    // Applies one request to the mirrored tree and returns its answer.
    function automatic answer_t predict_answer(input logic [FUNC_W-1:0] op,
                                               input logic [RANK_W-1:0] rank);
        int unsigned lim;
        int unsigned pos;
        longint unsigned prefix;
        answer_t ans;
        lim = used_size;
        if (lim < 1)
            lim = 1;
        if (lim > MAX_RANKS)
            lim = MAX_RANKS;
        ans = '0;
        if (op == FUNC_INSERT)
        begin
            if (inserted_total == COUNT_FULL)
            begin
                ans.rejected = 1'b1;
            end
            else if (rank >= 1 && rank <= lim)
            begin
                // Walk upward by the lowest set bit until past the limit.
                pos = rank;
                while (pos <= lim)
                begin
                    node_count[pos] = node_count[pos] + 1'b1;
                    pos = pos + (pos & (~pos + 1));
                end
                inserted_total = inserted_total + 1'b1;
            end
        end
        else
        begin
            // Prefix sum up to the saturated rank, walked downward.
            pos = (rank > lim) ? lim : rank;
            prefix = 0;
            while (pos != 0)
            begin
                prefix = prefix + node_count[pos];
                pos = pos - (pos & (~pos + 1));
            end
            if (prefix <= inserted_total)
                ans.greater_count = OUT_W'(inserted_total - prefix);
        end
        return ans;
    endfunction

    // Track registers and requests, then check results in order.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 1; i <= MAX_RANKS; i++)
                node_count[i] = '0;
            inserted_total = '0;
            used_size      = USED_SIZE_RESET;
            pending_answers.delete();
            n_pending = 0;
            n_errors  = 0;
        end
        else
        begin
            if (cfg_we)
                used_size = cfg_wdata;
            if (req.valid && req.ready)
                pending_answers.insert(pending_answers.size(),
                                       predict_answer(req.func, req.rank));
            if (res.valid && res.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result: expected none, actual greater_count=%0d rejected=%0d",
                             $time, res.greater_count, res.rejected);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (res.greater_count !== want.greater_count)
                    begin
                        n_errors++;
                        $display("%0t: greater_count mismatch: expected %0d, actual %0d",
                                 $time, want.greater_count, res.greater_count);
                    end
                    if (res.rejected !== want.rejected)
                    begin
                        n_errors++;
                        $display("%0t: rejected mismatch: expected %0d, actual %0d",
                                 $time, want.rejected, res.rejected);
                    end
                end
            end
            n_pending = pending_answers.size();
        end
    end

endmodule

// ===== tb/tb_fenwick_count_greater.sv =====
// ----------------------------------------------------------------------------
// Fenwick count-greater testbench
// Drives insert and query requests into the rank counter under several rank
// limits and idle patterns, holds the result port off for a long stretch,
// and ends with queries at the smallest and the full rank limit. The checker
// beside the block predicts every answer; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fenwick_count_greater;
    import fcg_pkg::*;

    localparam int MAX_RANKS   = 1024;
    localparam int COUNT_BITS  = 16;
    localparam int QUIET_LIMIT = 6000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    int n_pending;
    int n_errors;
    int snd_gap_pct     = 0;
    int rcv_gap_pct     = 0;
    int hold_off_cycles = 0;
    int quiet_cycles    = 0;

    fcg_item_if   req_ch ();
    fcg_result_if res_ch ();

    fenwick_count_greater #(
        .MAX_RANKS  (MAX_RANKS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (req_ch),
        .result    (res_ch)
    );

    fcg_answer_checker #(
        .MAX_RANKS  (MAX_RANKS),
        .COUNT_BITS (COUNT_BITS)
    ) answer_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch),
        .n_pending (n_pending),
        .n_errors  (n_errors)
    );

    // 2 ns clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog: ends the run when no request and no result moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is asked.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            res_ch.ready <= ($urandom_range(99) >= rcv_gap_pct);
        end
    end

    // Offers one request, with random idle cycles first; returns at the
    // falling edge after acceptance with valid still high.
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [RANK_W-1:0] rank);
        while ($urandom_range(99) < snd_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.rank  <= rank;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drops valid and waits until every answer has come back.
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (n_pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_used_size(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random inserts and queries; most ranks lie inside the limit.
    task automatic run_random(input int n_items, input int lim, input int hold_at);
        int pick;
        logic [FUNC_W-1:0] op;
        logic [RANK_W-1:0] rank;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                hold_off_cycles = 300;
            op = ($urandom_range(99) < 55) ? FUNC_INSERT : FUNC_QUERY;
            pick = $urandom_range(99);
            if (pick < 8)
                rank = '0;
            else if (pick < 18)
                rank = RANK_W'($urandom_range(2047, lim + 1));
            else
                rank = RANK_W'($urandom_range(lim, 1));
            send_request(op, rank);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_INSERT;
        req_ch.rank  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests at the reset limit: empty tree, ignored ranks,
        // both ends of the rank range and queries above the limit.
        snd_gap_pct = 37;
        rcv_gap_pct = 88;
        send_request(FUNC_QUERY, 11'd0);
        send_request(FUNC_QUERY, 11'd1024);
        send_request(FUNC_INSERT, 11'd0);
        send_request(FUNC_INSERT, 11'd1025);
        send_request(FUNC_INSERT, 11'd2047);
        send_request(FUNC_INSERT, 11'd1);
        send_request(FUNC_INSERT, 11'd1024);
        send_request(FUNC_INSERT, 11'd512);
        send_request(FUNC_INSERT, 11'd513);
        send_request(FUNC_INSERT, 11'd1023);
        send_request(FUNC_INSERT, 11'd2);
        send_request(FUNC_INSERT, 11'd1024);
        send_request(FUNC_QUERY, 11'd0);
        send_request(FUNC_QUERY, 11'd1);
        send_request(FUNC_QUERY, 11'd2);
        send_request(FUNC_QUERY, 11'd511);
        send_request(FUNC_QUERY, 11'd512);
        send_request(FUNC_QUERY, 11'd1023);
        send_request(FUNC_QUERY, 11'd1024);
        send_request(FUNC_QUERY, 11'd1025);
        send_request(FUNC_QUERY, 11'd2047);
        drain_requests();

        // Small limit: inserts above it from before still count in the total.
        write_used_size(11'd16);
        run_random(200, 16, -1);
        drain_requests();

        // Limit written above the rank range saturates to the top rank.
        snd_gap_pct = 88;
        rcv_gap_pct = 37;
        write_used_size(11'd2047);
        run_random(200, 1024, -1);
        drain_requests();

        // Zero limit behaves as one; then a long receiver hold-off.
        snd_gap_pct = 0;
        rcv_gap_pct = 0;
        write_used_size(11'd0);
        run_random(50, 1, -1);
        drain_requests();
        write_used_size(11'd700);
        run_random(150, 700, 40);
        drain_requests();

        // Limit of one: only rank one is kept, then the full limit again.
        write_used_size(11'd1);
        send_request(FUNC_INSERT, 11'd0);
        send_request(FUNC_QUERY, 11'd0);
        send_request(FUNC_QUERY, 11'd1);
        drain_requests();
        write_used_size(11'd1024);
        send_request(FUNC_QUERY, 11'd0);
        send_request(FUNC_QUERY, 11'd500);
        send_request(FUNC_QUERY, 11'd1024);
        send_request(FUNC_INSERT, 11'd5);
        drain_requests();

        if (n_errors == 0 && n_pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== fenwick_count_greater.f =====
+incdir+rtl
rtl/fcg_pkg.sv
rtl/fcg_item_if.sv
rtl/fcg_result_if.sv
rtl/fcg_ram.sv
rtl/fcg_walk.sv
rtl/fenwick_count_greater.sv
tb/fcg_answer_checker.sv
tb/tb_fenwick_count_greater.sv
